@@ design/rhci_pkg.sv @@
package rhci_pkg;

   localparam int MaxRegions = 16;
   localparam int SlotBits   = 4;
   localparam int CountBits  = 5;
   localparam int CoordBits  = 16;
   localparam int SizeBits   = 16;
   localparam int ColsBits   = 17;
   localparam int IndexBits  = 32;

   // One table entry as stored in the region memory.
   localparam int EntryBits  = 4 * CoordBits + 2 * SizeBits + ColsBits;

   typedef logic [0:0] op_type;
   localparam op_type OpWrite    = 1'b0;
   localparam op_type OpClassify = 1'b1;

   typedef struct packed {
      logic signed [CoordBits-1:0] left;
      logic signed [CoordBits-1:0] top;
      logic signed [CoordBits-1:0] right;
      logic signed [CoordBits-1:0] bottom;
      logic [SizeBits-1:0]         col_size;
      logic [SizeBits-1:0]         row_size;
      logic [ColsBits-1:0]         cols;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WDIV,
      ST_WWAIT,
      ST_WSTORE,
      ST_READ,
      ST_TEST,
      ST_DIVX,
      ST_WAITX,
      ST_DIVY,
      ST_WAITY,
      ST_MUL,
      ST_DONE
   } state_type;

   // Handshake between the sequencer and the divider.
   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

@@ design/rhci_ram.sv @@
module rhci_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Single write port, registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/rhci_div.sv @@
module rhci_div
   import rhci_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  div_ctl_type         ctl,
   input  logic [ColsBits-1:0] dividend,
   input  logic [SizeBits-1:0] divisor,
   output div_sts_type         sts,
   output logic [ColsBits-1:0] quotient
);

   localparam int StepBits = $clog2(ColsBits + 1);

   logic [ColsBits-1:0] quo_ff, quo_in;
   logic [SizeBits:0]   rem_ff, rem_in;
   logic [SizeBits-1:0] dsr_ff, dsr_in;
   logic [StepBits-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [SizeBits+1:0] trial;

   // Restoring division, one quotient bit per cycle.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[ColsBits-1]} - {2'b00, dsr_ff};
      if (ctl.start) begin
         quo_in  = dividend;
         rem_in  = '0;
         // A zero cell size counts as one.
         dsr_in  = (divisor == '0) ? SizeBits'(1) : divisor;
         cnt_in  = StepBits'(ColsBits);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial[SizeBits+1]) begin
            rem_in = {rem_ff[SizeBits-1:0], quo_ff[ColsBits-1]};
            quo_in = {quo_ff[ColsBits-2:0], 1'b0};
         end else begin
            rem_in = trial[SizeBits:0];
            quo_in = {quo_ff[ColsBits-2:0], 1'b1};
         end
         cnt_in = cnt_ff - StepBits'(1);
         if (cnt_ff == StepBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quotient = quo_ff;

   // A finished division always follows a busy cycle.
   assert property (@(posedge clock) disable iff (reset) done_ff |-> $past(busy_ff))
      else $error("divider done without busy");
   // Busy and done never overlap.
   assert property (@(posedge clock) disable iff (reset) !(busy_ff && done_ff))
      else $error("divider busy and done together");
   // The remainder stays below the divisor while working.
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff < {1'b0, dsr_ff}))
      else $error("divider remainder out of range");

endmodule

@@ design/region_hit_cell_index_core.sv @@
// Region hit test with grid cell index, one item at a time.
// Write item: one 17-step divide for the column count, skipped for an inverted width.
// Classify item: each region scanned is read, then tested; a hit adds two 17-step
// divides and one multiply; the result strobe comes in the last cycle.
// Sync reset clears the sequencer and region_count; table contents are undefined.
// The receiver cannot stall; busy is high from acceptance until the item is done.
module region_hit_cell_index_core
   import rhci_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_operation,
   input  logic [SlotBits-1:0]         req_slot,
   input  logic signed [CoordBits-1:0] req_rect_left,
   input  logic signed [CoordBits-1:0] req_rect_top,
   input  logic signed [CoordBits-1:0] req_rect_right,
   input  logic signed [CoordBits-1:0] req_rect_bottom,
   input  logic [SizeBits-1:0]         req_col_size,
   input  logic [SizeBits-1:0]         req_row_size,
   input  logic signed [CoordBits-1:0] req_x_coord,
   input  logic signed [CoordBits-1:0] req_y_coord,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CountBits-1:0]        csr_data,
   output logic                        rsp_strobe,
   output logic [CountBits-1:0]        rsp_region_hit,
   output logic [IndexBits-1:0]        rsp_cell_index
);

   state_type            state_ff, state_in;
   logic [CountBits-1:0] count_ff;
   entry_type            item_ff, item_in;
   logic signed [CoordBits-1:0] x_ff, x_in, y_ff, y_in;
   logic [CountBits-1:0] idx_ff, idx_in;
   logic [ColsBits-1:0]  ox_ff, ox_in, oy_ff, oy_in;
   entry_type            hit_ff, hit_in;
   logic [IndexBits-1:0] cell_ff, cell_in;
   logic [CountBits-1:0] rhit_ff, rhit_in;
   logic                 strobe_ff, strobe_in;

   logic                 ram_we;
   logic [EntryBits-1:0] ram_rd;
   entry_type            rd_entry;
   div_ctl_type          div_ctl;
   div_sts_type          div_sts;
   logic [ColsBits-1:0]  div_a, div_q;
   logic [SizeBits-1:0]  div_b;
   logic [CountBits-1:0] limit;
   logic                 inside_hit;
   logic signed [CoordBits:0] span;

   assign rd_entry = entry_type'(ram_rd);
   assign limit = (count_ff > CountBits'(MaxRegions)) ? CountBits'(MaxRegions) : count_ff;

   // Containment test on the entry just read.
   assign inside_hit = (x_ff >= rd_entry.left) && (x_ff <= rd_entry.right)
                    && (y_ff >= rd_entry.top)  && (y_ff <= rd_entry.bottom);

   assign span = {item_ff.right[CoordBits-1], item_ff.right}
               - {item_ff.left[CoordBits-1], item_ff.left} + (CoordBits+1)'(1);

   rhci_ram #(.Width(EntryBits), .Depth(MaxRegions)) u_table (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(SlotBits'(idx_ff)),
      .wr_data(EntryBits'(item_ff)),
      .rd_addr(SlotBits'(idx_ff)),
      .rd_data(ram_rd)
   );

   rhci_div u_div (
      .clock   (clock),
      .reset   (reset),
      .ctl     (div_ctl),
      .dividend(div_a),
      .divisor (div_b),
      .sts     (div_sts),
      .quotient(div_q)
   );

   // Sequencer: next state and datapath updates.
   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      idx_in    = idx_ff;
      ox_in     = ox_ff;
      oy_in     = oy_ff;
      hit_in    = hit_ff;
      cell_in   = cell_ff;
      rhit_in   = rhit_ff;
      strobe_in = 1'b0;
      ram_we    = 1'b0;
      div_ctl.start = 1'b0;
      div_a     = '0;
      div_b     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start && !busy) begin
               item_in.left     = req_rect_left;
               item_in.top      = req_rect_top;
               item_in.right    = req_rect_right;
               item_in.bottom   = req_rect_bottom;
               item_in.col_size = req_col_size;
               item_in.row_size = req_row_size;
               item_in.cols     = '0;
               x_in   = req_x_coord;
               y_in   = req_y_coord;
               rhit_in = '0;
               cell_in = '0;
               if (req_operation == OpWrite) begin
                  idx_in   = {1'b0, req_slot};
                  state_in = ST_WDIV;
               end else begin
                  idx_in   = '0;
                  state_in = (limit == '0) ? ST_DONE : ST_READ;
               end
            end
         end
         ST_WDIV: begin
            if (item_ff.right < item_ff.left) begin
               state_in = ST_WSTORE;
            end else begin
               div_ctl.start = 1'b1;
               div_a    = span[ColsBits-1:0];
               div_b    = item_ff.col_size;
               state_in = ST_WWAIT;
            end
         end
         ST_WWAIT: begin
            if (div_sts.done) begin
               item_in.cols = div_q;
               state_in     = ST_WSTORE;
            end
         end
         ST_WSTORE: begin
            ram_we   = 1'b1;
            state_in = ST_IDLE;
         end
         // The address is presented here; data is valid in ST_TEST.
         ST_READ: begin
            state_in = ST_TEST;
         end
         ST_TEST: begin
            if (inside_hit) begin
               hit_in   = rd_entry;
               rhit_in  = idx_ff + CountBits'(1);
               state_in = ST_DIVX;
            end else if (idx_ff + CountBits'(1) >= limit) begin
               state_in = ST_DONE;
            end else begin
               idx_in   = idx_ff + CountBits'(1);
               state_in = ST_READ;
            end
         end
         // The offsets are never negative, so they enter the divider zero-extended.
         ST_DIVX: begin
            div_ctl.start = 1'b1;
            div_a    = {1'b0, CoordBits'(x_ff - hit_ff.left)};
            div_b    = hit_ff.col_size;
            state_in = ST_WAITX;
         end
         ST_WAITX: begin
            if (div_sts.done) begin
               ox_in    = div_q;
               state_in = ST_DIVY;
            end
         end
         ST_DIVY: begin
            div_ctl.start = 1'b1;
            div_a    = {1'b0, CoordBits'(y_ff - hit_ff.top)};
            div_b    = hit_ff.row_size;
            state_in = ST_WAITY;
         end
         ST_WAITY: begin
            if (div_sts.done) begin
               oy_in    = div_q;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cell_in  = IndexBits'(hit_ff.cols) * IndexBits'(oy_ff) + IndexBits'(ox_ff);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      item_ff <= item_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      idx_ff  <= idx_in;
      ox_ff   <= ox_in;
      oy_ff   <= oy_in;
      hit_ff  <= hit_in;
      cell_ff <= cell_in;
      rhit_ff <= rhit_in;
   end

   // Configuration register transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         count_ff <= csr_data;
      end
   end

   assign csr_ready      = 1'b1;
   assign busy           = (state_ff != ST_IDLE) || strobe_ff;
   assign rsp_strobe     = strobe_ff;
   assign rsp_region_hit = rhit_ff;
   assign rsp_cell_index = cell_ff;

   // A result always leaves from the final state.
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |-> $past(state_ff == ST_DONE))
      else $error("result without done state");
   // No hit means a zero cell index.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_region_hit == '0) |-> (rsp_cell_index == '0))
      else $error("cell index without hit");
   // The divider is only started when idle.
   assert property (@(posedge clock) disable iff (reset) div_ctl.start |-> !div_sts.busy)
      else $error("divider restarted while busy");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
   import rhci_pkg::*;

   // One input item as it crosses the request ports.
   typedef struct {
      op_type                      op;
      logic [SlotBits-1:0]         slot;
      logic signed [CoordBits-1:0] left;
      logic signed [CoordBits-1:0] top;
      logic signed [CoordBits-1:0] right;
      logic signed [CoordBits-1:0] bottom;
      logic [SizeBits-1:0]         col_size;
      logic [SizeBits-1:0]         row_size;
      logic signed [CoordBits-1:0] x;
      logic signed [CoordBits-1:0] y;
   } region_item;

   typedef struct {
      logic [CountBits-1:0] hit;
      logic [IndexBits-1:0] index;
   } hit_result;

   // Keeps a copy of the region table and the expected hit results.
   class hit_scoreboard;
      int errors;
      int unsigned region_count;
      int tbl_left[MaxRegions];
      int tbl_top[MaxRegions];
      int tbl_right[MaxRegions];
      int tbl_bottom[MaxRegions];
      int tbl_col_size[MaxRegions];
      int tbl_row_size[MaxRegions];
      longint tbl_cols[MaxRegions];
      hit_result expected_hits[$];

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      function int pending();
         return expected_hits.size();
      endfunction

      function void set_count(logic [CountBits-1:0] value);
         region_count = value;
      endfunction

      // Updates the table on a write transfer, predicts the result of a classify.
      function void note_item(region_item it);
         int s, lim, cs, rs;
         hit_result res;
         if (it.op == OpWrite) begin
            s = it.slot;
            tbl_left[s] = it.left;
            tbl_top[s] = it.top;
            tbl_right[s] = it.right;
            tbl_bottom[s] = it.bottom;
            tbl_col_size[s] = it.col_size;
            tbl_row_size[s] = it.row_size;
            cs = (it.col_size == 0) ? 1 : int'(it.col_size);
            if (tbl_right[s] < tbl_left[s])
               tbl_cols[s] = 0;
            else
               tbl_cols[s] = (tbl_right[s] - tbl_left[s] + 1) / cs;
            return;
         end
         res.hit = '0;
         res.index = '0;
         lim = (region_count > MaxRegions) ? MaxRegions : region_count;
         for (int c = 0; c < lim; c++) begin
            if (int'(it.x) >= tbl_left[c] && int'(it.x) <= tbl_right[c] &&
                int'(it.y) >= tbl_top[c] && int'(it.y) <= tbl_bottom[c]) begin
               cs = (tbl_col_size[c] == 0) ? 1 : tbl_col_size[c];
               rs = (tbl_row_size[c] == 0) ? 1 : tbl_row_size[c];
               res.hit = CountBits'(c + 1);
               res.index = IndexBits'(tbl_cols[c] * longint'((int'(it.y) - tbl_top[c]) / rs)
                                      + longint'((int'(it.x) - tbl_left[c]) / cs));
               break;
            end
         end
         expected_hits.push_back(res);
      endfunction

      // Compares one result transfer with the oldest expectation.
      task check(logic [CountBits-1:0] hit, logic [IndexBits-1:0] index);
         hit_result exp_res;
         if (expected_hits.size() == 0) begin
            report($sformatf("unexpected result hit=%0d index=%0d", hit, index));
            return;
         end
         exp_res = expected_hits.pop_front();
         if (hit !== exp_res.hit)
            report($sformatf("region_hit %0d, expected %0d", hit, exp_res.hit));
         if (index !== exp_res.index)
            report($sformatf("cell_index %0d, expected %0d", index, exp_res.index));
      endtask
   endclass

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic                        req_operation;
   logic [SlotBits-1:0]         req_slot;
   logic signed [CoordBits-1:0] req_rect_left;
   logic signed [CoordBits-1:0] req_rect_top;
   logic signed [CoordBits-1:0] req_rect_right;
   logic signed [CoordBits-1:0] req_rect_bottom;
   logic [SizeBits-1:0]         req_col_size;
   logic [SizeBits-1:0]         req_row_size;
   logic signed [CoordBits-1:0] req_x_coord;
   logic signed [CoordBits-1:0] req_y_coord;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CountBits-1:0]        csr_data;
   logic                        rsp_strobe;
   logic [CountBits-1:0]        rsp_region_hit;
   logic [IndexBits-1:0]        rsp_cell_index;

   hit_scoreboard sb = new();

   // Stimulus-side copy of the rectangles, used to aim points inside them.
   int shadow_left[MaxRegions];
   int shadow_top[MaxRegions];
   int shadow_right[MaxRegions];
   int shadow_bottom[MaxRegions];
   int unsigned active_count;

   region_hit_cell_index_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_slot(req_slot),
      .req_rect_left(req_rect_left), .req_rect_top(req_rect_top),
      .req_rect_right(req_rect_right), .req_rect_bottom(req_rect_bottom),
      .req_col_size(req_col_size), .req_row_size(req_row_size),
      .req_x_coord(req_x_coord), .req_y_coord(req_y_coord),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .rsp_strobe(rsp_strobe), .rsp_region_hit(rsp_region_hit),
      .rsp_cell_index(rsp_cell_index)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watch every channel: note accepted transfers, check results.
   always @(posedge clock) begin
      region_item seen;
      if (!reset) begin
         if (start && !busy) begin
            seen.op = req_operation;
            seen.slot = req_slot;
            seen.left = req_rect_left;
            seen.top = req_rect_top;
            seen.right = req_rect_right;
            seen.bottom = req_rect_bottom;
            seen.col_size = req_col_size;
            seen.row_size = req_row_size;
            seen.x = req_x_coord;
            seen.y = req_y_coord;
            sb.note_item(seen);
         end
         if (csr_valid && csr_ready)
            sb.set_count(csr_data);
         if (rsp_strobe === 1'b1)
            sb.check(rsp_region_hit, rsp_cell_index);
      end
   end

   // Presents one item and holds it until the transfer happens.
   task send_item(region_item it);
      start <= 1'b1;
      req_operation <= it.op;
      req_slot <= it.slot;
      req_rect_left <= it.left;
      req_rect_top <= it.top;
      req_rect_right <= it.right;
      req_rect_bottom <= it.bottom;
      req_col_size <= it.col_size;
      req_row_size <= it.row_size;
      req_x_coord <= it.x;
      req_y_coord <= it.y;
      if (it.op == OpWrite) begin
         shadow_left[it.slot] = it.left;
         shadow_top[it.slot] = it.top;
         shadow_right[it.slot] = it.right;
         shadow_bottom[it.slot] = it.bottom;
      end
      do @(posedge clock); while (busy);
   endtask

   task pause_sender(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Drains all results, lets a trailing write finish, then writes the count.
   task write_count(logic [CountBits-1:0] value);
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() > 0 || busy) @(posedge clock);
      repeat (50) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      active_count = (value > MaxRegions) ? MaxRegions : value;
   endtask

   function automatic region_item blank_item();
      region_item it;
      it.op = OpClassify;
      it.slot = '0;
      it.left = '0;
      it.top = '0;
      it.right = '0;
      it.bottom = '0;
      it.col_size = 16'd1;
      it.row_size = 16'd1;
      it.x = '0;
      it.y = '0;
      return it;
   endfunction

   function automatic region_item make_rect(int s, int l, int t, int r, int b, int cs, int rs);
      region_item it = blank_item();
      it.op = OpWrite;
      it.slot = SlotBits'(s);
      it.left = CoordBits'(l);
      it.top = CoordBits'(t);
      it.right = CoordBits'(r);
      it.bottom = CoordBits'(b);
      it.col_size = SizeBits'(cs);
      it.row_size = SizeBits'(rs);
      it.x = CoordBits'($urandom);
      it.y = CoordBits'($urandom);
      return it;
   endfunction

   function automatic region_item make_point(int x, int y);
      region_item it = blank_item();
      it.x = CoordBits'(x);
      it.y = CoordBits'(y);
      it.slot = SlotBits'($urandom);
      it.left = CoordBits'($urandom);
      it.right = CoordBits'($urandom);
      return it;
   endfunction

   // Picks one edge span: mostly narrow, sometimes wide, now and then inverted.
   function automatic void random_span(output int lo, output int hi);
      int w;
      lo = int'($urandom_range(0, 65535)) - 32768;
      w = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 65535))
                                      : int'($urandom_range(0, 400));
      hi = (lo + w > 32767) ? 32767 : lo + w;
      if ($urandom_range(0, 11) == 0 && lo > -32700)
         hi = lo - 1 - int'($urandom_range(0, 50));
   endfunction

   function automatic int random_size();
      return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 32768))
                                         : int'($urandom_range(1, 64));
   endfunction

   function automatic region_item random_write();
      int l, t, r, b;
      random_span(l, r);
      random_span(t, b);
      return make_rect($urandom_range(0, MaxRegions - 1), l, t, r, b,
                       random_size(), random_size());
   endfunction

   // Mostly points inside a counted rectangle, some on its edges, some anywhere.
   function automatic region_item random_classify();
      int s, x, y, pick;
      pick = $urandom_range(0, 9);
      if (active_count == 0 || pick < 2)
         return make_point(int'($urandom_range(0, 65535)) - 32768,
                           int'($urandom_range(0, 65535)) - 32768);
      s = $urandom_range(0, active_count - 1);
      if (shadow_right[s] < shadow_left[s] || shadow_bottom[s] < shadow_top[s])
         return make_point(shadow_left[s], shadow_top[s]);
      if (pick < 4) begin
         x = $urandom_range(0, 1) ? shadow_left[s] : shadow_right[s];
         y = $urandom_range(0, 1) ? shadow_top[s] : shadow_bottom[s];
      end else begin
         x = shadow_left[s] + int'($urandom_range(0, shadow_right[s] - shadow_left[s]));
         y = shadow_top[s] + int'($urandom_range(0, shadow_bottom[s] - shadow_top[s]));
      end
      return make_point(x, y);
   endfunction

   initial begin
      int phase_counts[6];
      int l, t, r, b;
      bit tail;
      reset <= 1'b1;
      start <= 1'b0;
      csr_valid <= 1'b0;
      csr_data <= '0;
      req_operation <= OpWrite;
      req_slot <= '0;
      req_rect_left <= '0;
      req_rect_top <= '0;
      req_rect_right <= '0;
      req_rect_bottom <= '0;
      req_col_size <= '0;
      req_row_size <= '0;
      req_x_coord <= '0;
      req_y_coord <= '0;
      active_count = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // With a count of zero nothing can be hit.
      send_item(make_point(0, 0));
      send_item(make_point(32767, -32768));

      // Corner rectangle, inverted width, inverted height, a few ordinary ones,
      // and a full-plane region in the last slot.
      send_item(make_rect(0, 32000, -32768, 32767, -32000, 32768, 3));
      send_item(make_rect(1, 100, 100, 50, 200, 1, 1));
      send_item(make_rect(2, -500, 300, -400, 200, 2, 2));
      for (int s = 3; s < MaxRegions - 1; s++) begin
         random_span(l, r);
         if (r < l) r = l;
         random_span(t, b);
         if (b < t) b = t;
         send_item(make_rect(s, l, t, r, b, random_size(), random_size()));
      end
      send_item(make_rect(MaxRegions - 1, -32768, -32768, 32767, 32767, 1, 1));
      write_count(CountBits'(MaxRegions));
      send_item(make_point(32767, -32768));
      send_item(make_point(32000, -32000));
      send_item(make_point(-32768, -32768));
      send_item(make_point(32767, 32767));
      send_item(make_point(100, 150));
      send_item(make_point(-450, 250));

      // Random phases, each with its own region count; the last has no gaps.
      phase_counts = '{31, 1, 0, 16, 0, 16};
      phase_counts[2] = $urandom_range(2, 15);
      phase_counts[4] = $urandom_range(17, 30);
      foreach (phase_counts[p]) begin
         tail = (p == 5);
         write_count(CountBits'(phase_counts[p]));
         for (int n = 0; n < 150; n++) begin
            if ($urandom_range(0, 4) == 0)
               send_item(random_write());
            else
               send_item(random_classify());
            if (!tail && $urandom_range(0, 3) == 0)
               pause_sender($urandom_range(1, 11));
         end
      end

      start <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (sb.errors == 0)
         $display("** region_hit_cell_index_core: PASSED **");
      else
         $display("** region_hit_cell_index_core: FAILED **");
      $finish;
   end

   // Hard stop in case the block hangs.
   initial begin
      #20_000_000;
      $display("** region_hit_cell_index_core: FAILED **");
      $finish;
   end

endmodule
